// File: design/block_cipher_128_encrypt_macros.svh
// assertion macros for the block cipher encryption block
`ifndef BLOCK_CIPHER_128_ENCRYPT_MACROS_SVH
`define BLOCK_CIPHER_128_ENCRYPT_MACROS_SVH

// a property that must hold at every clock edge outside reset
`define BC_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// an implication checked in the next cycle
`define BC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/bc128_pkg.sv
// shared types, constants and functions of the block cipher encryption block
package bc128_pkg;

    localparam int BLOCK_BYTES = 16;

    typedef logic [7:0] byte_t;
    typedef logic [127:0] block_t;

    localparam logic [1:0] REG_KEY_HIGH = 2'd0;
    localparam logic [1:0] REG_KEY_LOW  = 2'd1;

    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] GF_POLY    = 8'h1b;
    localparam logic [7:0] GF_MSB     = 8'h80;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // multiply by x in gf(2^8)
    function automatic byte_t xtime(input byte_t a);
        byte_t b;
        b = {a[6:0], 1'b0};
        if ((a & GF_MSB) != 8'h00)
        begin
            b = b ^ GF_POLY;
        end
        return b;
    endfunction

    // byte n of a block, byte 0 most significant
    function automatic byte_t get_byte(input block_t v, input int n);
        return v[127 - 8*n -: 8];
    endfunction

    // one key schedule step: next round key from the previous one
    function automatic block_t next_round_key(input block_t k, input byte_t rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

// File: design/bc128_round.sv
// one registered cipher round with its key schedule step
module bc128_round
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                last,
    input  logic                valid_in,
    input  bc128_pkg::block_t   state_in,
    input  bc128_pkg::block_t   key_in,
    input  bc128_pkg::byte_t    rcon_in,
    output logic                valid_out,
    output bc128_pkg::block_t   state_out,
    output bc128_pkg::block_t   key_out,
    output bc128_pkg::byte_t    rcon_out
);

    logic              valid_reg;
    bc128_pkg::block_t state_reg, state_next;
    bc128_pkg::block_t key_reg, key_next;
    bc128_pkg::byte_t  rcon_reg;
    bc128_pkg::block_t ss;
    bc128_pkg::block_t mixed;

    // sub bytes and shift rows
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                ss[127 - 8*(c*4 + r) -: 8] =
                    bc128_pkg::SBOX[bc128_pkg::get_byte(state_in, ((c + r) % 4)*4 + r)];
            end
        end
    end

    // mix columns
    always_comb
    begin
        bc128_pkg::byte_t a0, a1, a2, a3, all;
        for (int c = 0; c < 4; c++)
        begin
            a0 = bc128_pkg::get_byte(ss, c*4);
            a1 = bc128_pkg::get_byte(ss, c*4 + 1);
            a2 = bc128_pkg::get_byte(ss, c*4 + 2);
            a3 = bc128_pkg::get_byte(ss, c*4 + 3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 8*(c*4)     -: 8] = a0 ^ all ^ bc128_pkg::xtime(a0 ^ a1);
            mixed[127 - 8*(c*4 + 1) -: 8] = a1 ^ all ^ bc128_pkg::xtime(a1 ^ a2);
            mixed[127 - 8*(c*4 + 2) -: 8] = a2 ^ all ^ bc128_pkg::xtime(a2 ^ a3);
            mixed[127 - 8*(c*4 + 3) -: 8] = a3 ^ all ^ bc128_pkg::xtime(a3 ^ a0);
        end
    end

    assign key_next   = bc128_pkg::next_round_key(key_in, rcon_in);
    assign state_next = (last ? ss : mixed) ^ key_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        key_reg   <= key_next;
        rcon_reg  <= bc128_pkg::xtime(rcon_in);
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;
    assign key_out   = key_reg;
    assign rcon_out  = rcon_reg;

endmodule

// File: design/block_cipher_128_encrypt.sv
// top level of the pipelined aes-128 encryption block
// usage:
//   the key is written over the apb port: key_high at address 0, key_low at 8
//   (64-bit data); reads return the key; both reset to zero
//   an item enters when start is high and busy is low; busy is always low,
//   so one plaintext block can enter every clock cycle
//   block_high and block_low hold the plaintext, byte 0 most significant
//   one stage adds the initial round key, then one registered stage per
//   round follows, each also expanding its round key alongside the data
//   an item passes the key addition register, then the ROUNDS round registers,
//   before done rises with the result; throughput is one item per cycle, set
//   by the unrolled round stages
//   done is high for one cycle with cipher_high and cipher_low; the
//   receiver cannot stall, so results are never held back
//   reset clears all valid bits and the key; items in flight are dropped
//   each item carries the key it entered with, so write the key while idle
module block_cipher_128_encrypt
#(
    parameter int ROUNDS = 10
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    output logic        done,
    output logic [63:0] cipher_high,
    output logic [63:0] cipher_low
);

    `include "block_cipher_128_encrypt_macros.svh"

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    // pipeline taps: index 0 is the initial key addition stage
    logic              valid_tap [ROUNDS + 1];
    bc128_pkg::block_t state_tap [ROUNDS + 1];
    bc128_pkg::block_t key_tap   [ROUNDS + 1];
    bc128_pkg::byte_t  rcon_tap  [ROUNDS + 1];

    logic              valid0_reg;
    bc128_pkg::block_t state0_reg;
    bc128_pkg::block_t key0_reg;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign wr_en     = psel && penable && pwrite && pready;
    // registers sit eight bytes apart
    assign reg_index = {1'b0, paddr[3]};

    // key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (wr_en)
        begin
            if (reg_index == bc128_pkg::REG_KEY_HIGH)
            begin
                key_high_reg <= pwdata;
            end
            else if (reg_index == bc128_pkg::REG_KEY_LOW)
            begin
                key_low_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        case (reg_index)
            bc128_pkg::REG_KEY_HIGH: prdata = key_high_reg;
            bc128_pkg::REG_KEY_LOW:  prdata = key_low_reg;
            default:                 prdata = '0;
        endcase
    end

    // initial round key addition
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else
        begin
            valid0_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        state0_reg <= {block_high, block_low} ^ {key_high_reg, key_low_reg};
        key0_reg   <= {key_high_reg, key_low_reg};
    end

    assign valid_tap[0] = valid0_reg;
    assign state_tap[0] = state0_reg;
    assign key_tap[0]   = key0_reg;
    assign rcon_tap[0]  = bc128_pkg::RCON_FIRST;

    // one stage per round, the last without mix columns
    for (genvar g = 0; g < ROUNDS; g++)
    begin : g_round
        bc128_round u_round
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .last      (g == ROUNDS - 1),
            .valid_in  (valid_tap[g]),
            .state_in  (state_tap[g]),
            .key_in    (key_tap[g]),
            .rcon_in   (rcon_tap[g]),
            .valid_out (valid_tap[g + 1]),
            .state_out (state_tap[g + 1]),
            .key_out   (key_tap[g + 1]),
            .rcon_out  (rcon_tap[g + 1])
        );
    end

    assign done        = valid_tap[ROUNDS];
    assign cipher_high = state_tap[ROUNDS][127:64];
    assign cipher_low  = state_tap[ROUNDS][63:0];

    // an accepted item is in the key addition stage in the next cycle
    `BC_ASSERT_NEXT(a_stage0_follows, clk, rst_n, start, valid0_reg, "first stage lost an item")
    // the round stages only shift valid bits
    `BC_ASSERT_NEXT(a_valid_shift, clk, rst_n, valid_tap[ROUNDS - 1], done, "item lost in last round")
    // the interface never blocks an item
    `BC_ASSERT_ALWAYS(a_never_busy, clk, rst_n, !busy && pready, "port not ready")

endmodule
